// ----- sv/rgbw_pkg.sv -----
package rgbw_pkg;

   localparam int CHANNEL_BITS_DEF  = 16;
   localparam int FRACTION_BITS_DEF = 8;

   localparam int GAIN_BITS      = 16;
   localparam int COMP_BITS      = 16;
   localparam int MAXW_BITS      = 24;
   localparam int NUM_CHANNELS   = 3;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 24;

   // channel order inside packed per-channel arrays
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WHITE_RED   = 8'd0,
      CSR_WHITE_GREEN = 8'd1,
      CSR_WHITE_BLUE  = 8'd2,
      CSR_MAX_WHITE   = 8'd3
   } csr_index_type;

   localparam logic [COMP_BITS-1:0] WHITE_COMP_RESET = 16'd256;
   localparam logic [MAXW_BITS-1:0] MAX_WHITE_RESET  = 24'd65535;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0][COMP_BITS-1:0] comp;
      logic [MAXW_BITS-1:0]                   max_white;
   } cfg_type;

endpackage

// ----- sv/rgbw_if.sv -----
interface rgbw_req_if #(
   parameter int CHANNEL_BITS = rgbw_pkg::CHANNEL_BITS_DEF
);
   logic                           valid;
   logic                           ready;
   logic [CHANNEL_BITS-1:0]        in_red;
   logic [CHANNEL_BITS-1:0]        in_green;
   logic [CHANNEL_BITS-1:0]        in_blue;
   logic [rgbw_pkg::GAIN_BITS-1:0] gain;

   modport source (output valid, in_red, in_green, in_blue, gain, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, gain, output ready);
endinterface

interface rgbw_rsp_if #(
   parameter int OUT_BITS = rgbw_pkg::CHANNEL_BITS_DEF + rgbw_pkg::FRACTION_BITS_DEF
);
   logic                           valid;
   logic                           ready;
   logic [OUT_BITS-1:0]            out_red;
   logic [OUT_BITS-1:0]            out_green;
   logic [OUT_BITS-1:0]            out_blue;
   logic [rgbw_pkg::MAXW_BITS-1:0] out_white;
   logic                           white_clamped;

   modport source (output valid, out_red, out_green, out_blue, out_white, white_clamped,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_white, white_clamped,
                   output ready);
endinterface

interface rgbw_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rgbw_pkg::CSR_INDEX_BITS-1:0] index;
   logic [rgbw_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/rgb_to_rgbw_white_extraction.sv -----
// RGB to RGBW conversion against a calibrated white LED.
// req_ch carries one pixel (in_red, in_green, in_blue) and a Q8.8 gain per item;
// rsp_ch returns the residual color drive, the white drive and a flag telling
// whether white hit the max_white ceiling. csr_ch writes the white LED's
// red/green/blue content and max_white; it is always ready and must only be
// written while no item is in flight.
// Throughput: one item per clock while req_ch.ready is high. An item passes through
// the gain multiply, the restoring divider (one quotient bit per stage for each
// channel), the min/clamp and white-share stages and the output register on its
// way to rsp_ch.
// Reset clears all valid bits and loads the register defaults (white content
// 256 per channel, max_white 65535).
// When rsp_ch stalls, one more item lands in a skid register behind the output
// register; once that is full req_ch.ready drops and the whole pipeline holds.
module rgb_to_rgbw_white_extraction #(
   parameter int CHANNEL_BITS  = rgbw_pkg::CHANNEL_BITS_DEF,
   parameter int FRACTION_BITS = rgbw_pkg::FRACTION_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rgbw_req_if.sink   req_ch,
   rgbw_rsp_if.source rsp_ch,
   rgbw_csr_if.sink   csr_ch
);
   import rgbw_pkg::*;

   localparam int OUT_BITS     = CHANNEL_BITS + FRACTION_BITS;
   localparam int NUM_BITS     = OUT_BITS + FRACTION_BITS;
   localparam int PAYLOAD_BITS = NUM_CHANNELS * OUT_BITS + MAXW_BITS + 1;

   cfg_type cfg;
   logic    en;

   logic                                  amp_valid;
   logic [NUM_CHANNELS-1:0][OUT_BITS-1:0] amp;
   logic                                  div_valid;
   logic [NUM_CHANNELS-1:0][OUT_BITS-1:0] div_amp;
   logic [NUM_CHANNELS-1:0][NUM_BITS-1:0] div_quo;
   logic                                  wht_valid;
   logic [NUM_CHANNELS-1:0][OUT_BITS-1:0] residual;
   logic [MAXW_BITS-1:0]                  white;
   logic                                  clamped;
   logic [PAYLOAD_BITS-1:0]               pay_in;
   logic [PAYLOAD_BITS-1:0]               pay_out;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = en;

   rgbw_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .cfg       (cfg)
   );

   rgbw_amp #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_amp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_red    (req_ch.in_red),
      .in_green  (req_ch.in_green),
      .in_blue   (req_ch.in_blue),
      .gain      (req_ch.gain),
      .out_valid (amp_valid),
      .amp       (amp)
   );

   rgbw_div #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (amp_valid),
      .in_amp    (amp),
      .comp      (cfg.comp),
      .out_valid (div_valid),
      .out_amp   (div_amp),
      .out_quo   (div_quo)
   );

   rgbw_white #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_white (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (div_valid),
      .in_amp    (div_amp),
      .in_quo    (div_quo),
      .out_valid (wht_valid),
      .residual  (residual),
      .white     (white),
      .clamped   (clamped)
   );

   assign pay_in = {residual[CH_RED], residual[CH_GREEN], residual[CH_BLUE], white, clamped};

   rgbw_out #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (wht_valid),
      .in_data   (pay_in),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (pay_out)
   );

   assign {rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue,
           rsp_ch.out_white, rsp_ch.white_clamped} = pay_out;

endmodule

// ----- sv/rgbw_cfg.sv -----
module rgbw_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [rgbw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rgbw_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output rgbw_pkg::cfg_type                   cfg
);
   import rgbw_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_WHITE_RED:   cfg_in.comp[CH_RED]   = csr_data[COMP_BITS-1:0];
            CSR_WHITE_GREEN: cfg_in.comp[CH_GREEN] = csr_data[COMP_BITS-1:0];
            CSR_WHITE_BLUE:  cfg_in.comp[CH_BLUE]  = csr_data[COMP_BITS-1:0];
            CSR_MAX_WHITE:   cfg_in.max_white      = csr_data[MAXW_BITS-1:0];
            default: begin
               // unknown index: drop the write
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.comp[CH_RED]   <= WHITE_COMP_RESET;
         cfg_ff.comp[CH_GREEN] <= WHITE_COMP_RESET;
         cfg_ff.comp[CH_BLUE]  <= WHITE_COMP_RESET;
         cfg_ff.max_white      <= MAX_WHITE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/rgbw_amp.sv -----
module rgbw_amp #(
   parameter int CHANNEL_BITS  = rgbw_pkg::CHANNEL_BITS_DEF,
   parameter int FRACTION_BITS = rgbw_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [CHANNEL_BITS-1:0]          in_red,
   input  logic [CHANNEL_BITS-1:0]          in_green,
   input  logic [CHANNEL_BITS-1:0]          in_blue,
   input  logic [rgbw_pkg::GAIN_BITS-1:0]   gain,
   output logic                             out_valid,
   output logic [rgbw_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS+FRACTION_BITS-1:0] amp
);
   import rgbw_pkg::*;

   localparam int OUT_BITS   = CHANNEL_BITS + FRACTION_BITS;
   localparam int PROD_BITS  = CHANNEL_BITS + GAIN_BITS;
   localparam int SHIFT_BITS = PROD_BITS - FRACTION_BITS;
   localparam int WIDE_BITS  = (SHIFT_BITS > OUT_BITS) ? SHIFT_BITS : OUT_BITS;

   logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan;
   logic [NUM_CHANNELS-1:0][PROD_BITS-1:0]    prod;
   logic [NUM_CHANNELS-1:0][WIDE_BITS-1:0]    wide;
   logic [NUM_CHANNELS-1:0][OUT_BITS-1:0]     amp_in;
   logic [NUM_CHANNELS-1:0][OUT_BITS-1:0]     amp_ff;
   logic                                      valid_ff;

   assign chan[CH_RED]   = in_red;
   assign chan[CH_GREEN] = in_green;
   assign chan[CH_BLUE]  = in_blue;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         prod[c] = PROD_BITS'(chan[c]) * PROD_BITS'(gain);
         wide[c] = WIDE_BITS'(prod[c] >> FRACTION_BITS);
         // saturate to the output range
         amp_in[c] = (wide[c] > WIDE_BITS'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
                                                             : OUT_BITS'(wide[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         amp_ff <= amp_in;
      end
   end

   assign out_valid = valid_ff;
   assign amp       = amp_ff;

endmodule

// ----- sv/rgbw_div.sv -----
module rgbw_div #(
   parameter int CHANNEL_BITS  = rgbw_pkg::CHANNEL_BITS_DEF,
   parameter int FRACTION_BITS = rgbw_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [rgbw_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS+FRACTION_BITS-1:0] in_amp,
   input  logic [rgbw_pkg::NUM_CHANNELS-1:0][rgbw_pkg::COMP_BITS-1:0]        comp,
   output logic out_valid,
   output logic [rgbw_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS+FRACTION_BITS-1:0] out_amp,
   output logic [rgbw_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS+2*FRACTION_BITS-1:0] out_quo
);
   import rgbw_pkg::*;

   localparam int OUT_BITS = CHANNEL_BITS + FRACTION_BITS;
   localparam int NUM_BITS = OUT_BITS + FRACTION_BITS;

   typedef logic [NUM_CHANNELS-1:0][OUT_BITS-1:0]  amp_vec_type;
   typedef logic [NUM_CHANNELS-1:0][COMP_BITS-1:0] rem_vec_type;
   typedef logic [NUM_CHANNELS-1:0][NUM_BITS-1:0]  quo_vec_type;

   // one restoring step per stage, quotient bit NUM_BITS-1-k decided in stage k
   logic [NUM_BITS-1:0] valid_ff;
   amp_vec_type         amp_ff  [NUM_BITS];
   rem_vec_type         rem_ff  [NUM_BITS];
   quo_vec_type         quo_ff  [NUM_BITS];
   amp_vec_type         prev_amp[NUM_BITS];
   rem_vec_type         prev_rem[NUM_BITS];
   quo_vec_type         prev_quo[NUM_BITS];
   rem_vec_type         rem_in  [NUM_BITS];
   quo_vec_type         quo_in  [NUM_BITS];

   always_comb begin
      prev_amp[0] = in_amp;
      prev_rem[0] = '0;
      prev_quo[0] = '0;
      for (int k = 1; k < NUM_BITS; k++) begin
         prev_amp[k] = amp_ff[k-1];
         prev_rem[k] = rem_ff[k-1];
         prev_quo[k] = quo_ff[k-1];
      end
   end

   always_comb begin
      logic [NUM_BITS-1:0]  num;
      logic [COMP_BITS:0]   trial;
      logic [COMP_BITS:0]   diff;
      logic                 ge;
      for (int k = 0; k < NUM_BITS; k++) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            num   = {prev_amp[k][c], {FRACTION_BITS{1'b0}}};
            trial = {prev_rem[k][c], num[NUM_BITS-1-k]};
            diff  = trial - {1'b0, comp[c]};
            ge    = (trial >= {1'b0, comp[c]});
            rem_in[k][c] = ge ? diff[COMP_BITS-1:0] : trial[COMP_BITS-1:0];
            quo_in[k][c] = {prev_quo[k][c][NUM_BITS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NUM_BITS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_BITS; k++) begin
            amp_ff[k] <= prev_amp[k];
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign out_valid = valid_ff[NUM_BITS-1];
   assign out_amp   = amp_ff[NUM_BITS-1];
   assign out_quo   = quo_ff[NUM_BITS-1];

endmodule

// ----- sv/rgbw_white.sv -----
module rgbw_white #(
   parameter int CHANNEL_BITS  = rgbw_pkg::CHANNEL_BITS_DEF,
   parameter int FRACTION_BITS = rgbw_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  rgbw_pkg::cfg_type cfg,
   input  logic in_valid,
   input  logic [rgbw_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS+FRACTION_BITS-1:0]   in_amp,
   input  logic [rgbw_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS+2*FRACTION_BITS-1:0] in_quo,
   output logic out_valid,
   output logic [rgbw_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS+FRACTION_BITS-1:0]   residual,
   output logic [rgbw_pkg::MAXW_BITS-1:0] white,
   output logic clamped
);
   import rgbw_pkg::*;

   localparam int OUT_BITS   = CHANNEL_BITS + FRACTION_BITS;
   localparam int NUM_BITS   = OUT_BITS + FRACTION_BITS;
   // one spare bit so an unlimited channel compares above any ceiling
   localparam int QW_BITS    = ((NUM_BITS > MAXW_BITS) ? NUM_BITS : MAXW_BITS) + 1;
   localparam int MUL_BITS   = MAXW_BITS + COMP_BITS;
   localparam int SHARE_BITS = MUL_BITS - FRACTION_BITS;
   localparam int CMP_BITS   = (SHARE_BITS > OUT_BITS) ? SHARE_BITS : OUT_BITS;
   localparam int STAGES     = 5;

   typedef logic [NUM_CHANNELS-1:0][OUT_BITS-1:0] amp_vec_type;

   logic [STAGES-1:0] valid_ff;

   // stage 1: extend, mark unlimited channels, min of red and green
   logic [NUM_CHANNELS-1:0][QW_BITS-1:0] qx;
   logic [QW_BITS-1:0]                    m1_min_in;
   logic [QW_BITS-1:0]                    m1_min_ff;
   logic [QW_BITS-1:0]                    m1_qb_ff;
   amp_vec_type                           m1_amp_ff;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         qx[c] = (cfg.comp[c] == '0) ? {QW_BITS{1'b1}} : QW_BITS'(in_quo[c]);
      end
      m1_min_in = (qx[CH_GREEN] < qx[CH_RED]) ? qx[CH_GREEN] : qx[CH_RED];
   end

   // stage 2: fold in blue
   logic [QW_BITS-1:0] m2_min_in;
   logic [QW_BITS-1:0] m2_min_ff;
   amp_vec_type        m2_amp_ff;

   assign m2_min_in = (m1_qb_ff < m1_min_ff) ? m1_qb_ff : m1_min_ff;

   // stage 3: clamp to the ceiling
   logic                 m3_clamped_in;
   logic [MAXW_BITS-1:0] m3_white_in;
   logic                 m3_clamped_ff;
   logic [MAXW_BITS-1:0] m3_white_ff;
   amp_vec_type          m3_amp_ff;

   assign m3_clamped_in = (m2_min_ff > QW_BITS'(cfg.max_white));
   assign m3_white_in   = m3_clamped_in ? cfg.max_white : MAXW_BITS'(m2_min_ff);

   // stage 4: white share per channel
   logic [NUM_CHANNELS-1:0][MUL_BITS-1:0]   mul;
   logic [NUM_CHANNELS-1:0][SHARE_BITS-1:0] share_in;
   logic [NUM_CHANNELS-1:0][SHARE_BITS-1:0] share_ff;
   logic                                    r1_clamped_ff;
   logic [MAXW_BITS-1:0]                    r1_white_ff;
   amp_vec_type                             r1_amp_ff;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         mul[c]      = MUL_BITS'(m3_white_ff) * MUL_BITS'(cfg.comp[c]);
         share_in[c] = SHARE_BITS'(mul[c] >> FRACTION_BITS);
      end
   end

   // stage 5: remove the share, floor at zero
   amp_vec_type          res_in;
   amp_vec_type          res_ff;
   logic                 r2_clamped_ff;
   logic [MAXW_BITS-1:0] r2_white_ff;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         res_in[c] = (CMP_BITS'(share_ff[c]) >= CMP_BITS'(r1_amp_ff[c])) ? '0 :
                     OUT_BITS'(CMP_BITS'(r1_amp_ff[c]) - CMP_BITS'(share_ff[c]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_min_ff     <= m1_min_in;
         m1_qb_ff      <= qx[CH_BLUE];
         m1_amp_ff     <= in_amp;
         m2_min_ff     <= m2_min_in;
         m2_amp_ff     <= m1_amp_ff;
         m3_clamped_ff <= m3_clamped_in;
         m3_white_ff   <= m3_white_in;
         m3_amp_ff     <= m2_amp_ff;
         share_ff      <= share_in;
         r1_clamped_ff <= m3_clamped_ff;
         r1_white_ff   <= m3_white_ff;
         r1_amp_ff     <= m3_amp_ff;
         res_ff        <= res_in;
         r2_clamped_ff <= r1_clamped_ff;
         r2_white_ff   <= r1_white_ff;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign residual  = res_ff;
   assign white     = r2_white_ff;
   assign clamped   = r2_clamped_ff;

endmodule

// ----- sv/rgbw_out.sv -----
module rgbw_out #(
   parameter int PAYLOAD_BITS = 3 * (rgbw_pkg::CHANNEL_BITS_DEF + rgbw_pkg::FRACTION_BITS_DEF)
                                + rgbw_pkg::MAXW_BITS + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   output logic                    en,
   input  logic                    in_valid,
   input  logic [PAYLOAD_BITS-1:0] in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [PAYLOAD_BITS-1:0] out_data
);
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [PAYLOAD_BITS-1:0] out_data_ff;
   logic [PAYLOAD_BITS-1:0] out_data_in;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   logic [PAYLOAD_BITS-1:0] skid_data_ff;
   logic [PAYLOAD_BITS-1:0] skid_data_in;

   // the pipeline advances as long as the skid slot is free
   assign en = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_ready) begin
         out_valid_in = in_valid;
         out_data_in  = in_data;
      end else if (in_valid) begin
         // output held by a stalled receiver: park the item
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ----- test/tb_rgb_to_rgbw_white_extraction.sv -----
module tb_rgb_to_rgbw_white_extraction;
   import rgbw_pkg::*;

   localparam int CH_W = CHANNEL_BITS_DEF;
   localparam int FRAC = FRACTION_BITS_DEF;
   localparam int OUT_W = CH_W + FRAC;
   localparam longint unsigned OUT_MAX = (64'd1 << OUT_W) - 64'd1;
   localparam int LATENCY = CH_W + 2 * FRAC + 6;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_PER_PHASE = 136;
   localparam int RANDOM_PHASES = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_PAST_END = 8'(CSR_MAX_WHITE + 1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_TOP = '1;

   typedef struct packed {
      logic [CH_W-1:0]      red;
      logic [CH_W-1:0]      green;
      logic [CH_W-1:0]      blue;
      logic [GAIN_BITS-1:0] gain;
   } pixel_type;

   typedef struct packed {
      logic [OUT_W-1:0]     red;
      logic [OUT_W-1:0]     green;
      logic [OUT_W-1:0]     blue;
      logic [MAXW_BITS-1:0] white;
      logic                 clamped;
   } rgbw_result_type;

   typedef struct packed {
      pixel_type       px;
      logic            typed;
      rgbw_result_type res;
   } directed_row_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] red;
      logic [CSR_DATA_BITS-1:0] green;
      logic [CSR_DATA_BITS-1:0] blue;
      logic [CSR_DATA_BITS-1:0] max_white;
   } white_setting_type;

   logic clock;
   logic reset;

   rgbw_req_if req_ch ();
   rgbw_rsp_if rsp_ch ();
   rgbw_csr_if csr_ch ();

   rgb_to_rgbw_white_extraction DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cfg_type         white_cfg;
   rgbw_result_type pending_rgbw [$];
   int              mismatches = 0;
   int              cycle_count = 0;
   int              stall_left = 0;
   bit              quiet = 1'b0;

   // rows under the reset register values; typed results are read straight off the formulas
   directed_row_type directed_rows [15] = '{
      '{'{16'h0000, 16'h0000, 16'h0000, 16'd256}, 1'b1, '{24'd0, 24'd0, 24'd0, 24'd0, 1'b0}},
      '{'{16'd1000, 16'd1000, 16'd1000, 16'd256}, 1'b1, '{24'd0, 24'd0, 24'd0, 24'd1000, 1'b0}},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd256}, 1'b1, '{24'd0, 24'd0, 24'd0, 24'd65535, 1'b0}},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{24'd16711169, 24'd16711169, 24'd16711169, 24'd65535, 1'b1}},
      '{'{16'hFFFF, 16'h0000, 16'h0000, 16'd256}, 1'b1, '{24'd65535, 24'd0, 24'd0, 24'd0, 1'b0}},
      '{'{16'h0000, 16'hFFFF, 16'h0000, 16'd256}, 1'b1, '{24'd0, 24'd65535, 24'd0, 24'd0, 1'b0}},
      '{'{16'h0000, 16'h0000, 16'hFFFF, 16'd256}, 1'b1, '{24'd0, 24'd0, 24'd65535, 24'd0, 1'b0}},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1, '{24'd0, 24'd0, 24'd0, 24'd0, 1'b0}},
      '{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0},
      '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0},
      '{'{16'd100, 16'd200, 16'd300, 16'd512}, 1'b0, '0},
      '{'{16'd1, 16'd1, 16'd1, 16'd1}, 1'b0, '0},
      '{'{16'hFFFF, 16'h8000, 16'h0001, 16'd256}, 1'b0, '0},
      '{'{16'd256, 16'd255, 16'd257, 16'd257}, 1'b0, '0},
      '{'{16'd1234, 16'd1234, 16'd1234, 16'hFFFF}, 1'b0, '0}
   };

   // extremes and the zero-content cases: one channel, two channels, all three
   white_setting_type fixed_settings [7] = '{
      '{24'd256, 24'd256, 24'd256, 24'd65535},
      '{24'd65535, 24'd65535, 24'd65535, 24'hFFFFFF},
      '{24'd1, 24'd1, 24'd1, 24'd0},
      '{24'd1, 24'd1, 24'd1, 24'hFFFFFF},
      '{24'd0, 24'd256, 24'd512, 24'd65535},
      '{24'd300, 24'd0, 24'd0, 24'd1000},
      '{24'd0, 24'd0, 24'd0, 24'd12345}
   };

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rgbw_result_type extract_white(pixel_type px);
      longint unsigned chan [NUM_CHANNELS];
      longint unsigned amp [NUM_CHANNELS];
      longint unsigned resid [NUM_CHANNELS];
      longint unsigned comp;
      longint unsigned units;
      longint unsigned share;
      longint unsigned white;
      rgbw_result_type res;
      chan[CH_RED] = px.red;
      chan[CH_GREEN] = px.green;
      chan[CH_BLUE] = px.blue;
      white = 64'hFFFF_FFFF_FFFF_FFFF;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         amp[i] = (chan[i] * longint'(px.gain)) >> FRAC;
         if (amp[i] > OUT_MAX) amp[i] = OUT_MAX;
         comp = white_cfg.comp[i];
         // a zero white content puts no bound on the white drive
         if (comp != 0) begin
            units = (amp[i] << FRAC) / comp;
            if (units < white) white = units;
         end
      end
      res.clamped = white > white_cfg.max_white;
      if (res.clamped) white = white_cfg.max_white;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         share = (white * longint'(white_cfg.comp[i])) >> FRAC;
         resid[i] = (share >= amp[i]) ? 64'd0 : amp[i] - share;
         if (resid[i] > OUT_MAX) resid[i] = OUT_MAX;
      end
      res.red = OUT_W'(resid[CH_RED]);
      res.green = OUT_W'(resid[CH_GREEN]);
      res.blue = OUT_W'(resid[CH_BLUE]);
      res.white = MAXW_BITS'(white);
      return res;
   endfunction

   function automatic int idle_len();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CH_W-1:0] pick_channel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return CH_W'($urandom_range(0, 255));
         3: return CH_W'(1) << $urandom_range(0, CH_W - 1);
         default: return CH_W'($urandom);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.red = pick_channel();
      px.green = pick_channel();
      px.blue = pick_channel();
      // near-gray pixels exercise the white share on every channel
      if ($urandom_range(0, 2) == 0) begin
         px.green = px.red + CH_W'($urandom_range(0, 15));
         px.blue = px.red - CH_W'($urandom_range(0, 15));
      end
      case ($urandom_range(0, 5))
         0: px.gain = GAIN_BITS'(256);
         1: px.gain = GAIN_BITS'($urandom_range(0, 1023));
         2: px.gain = '1;
         default: px.gain = GAIN_BITS'($urandom);
      endcase
      return px;
   endfunction

   function automatic white_setting_type random_setting();
      white_setting_type s;
      s.red = ($urandom_range(0, 4) == 0) ? '0 : CSR_DATA_BITS'($urandom);
      s.green = ($urandom_range(0, 4) == 0) ? '0 : CSR_DATA_BITS'($urandom);
      s.blue = ($urandom_range(0, 4) == 0) ? '0 : CSR_DATA_BITS'($urandom);
      case ($urandom_range(0, 3))
         0: s.max_white = '0;
         1: s.max_white = '1;
         default: s.max_white = CSR_DATA_BITS'($urandom);
      endcase
      return s;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_ch.index = index;
      csr_ch.data = data;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (index)
         CSR_WHITE_RED: white_cfg.comp[CH_RED] = data[COMP_BITS-1:0];
         CSR_WHITE_GREEN: white_cfg.comp[CH_GREEN] = data[COMP_BITS-1:0];
         CSR_WHITE_BLUE: white_cfg.comp[CH_BLUE] = data[COMP_BITS-1:0];
         CSR_MAX_WHITE: white_cfg.max_white = data[MAXW_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic send_pixel(input pixel_type px, input rgbw_result_type res);
      int gap;
      gap = idle_len();
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.in_red = px.red;
      req_ch.in_green = px.green;
      req_ch.in_blue = px.blue;
      req_ch.gain = px.gain;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_rgbw.push_back(res);
      // leave valid high; the next call drops it only for a gap
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (pending_rgbw.size() != 0) @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) stall_left = idle_len();
      if (stall_left != 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      rgbw_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_rgbw.size() == 0) begin
            $error("unexpected rgbw item: red %0d green %0d blue %0d white %0d clamped %0d",
                   rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue, rsp_ch.out_white,
                   rsp_ch.white_clamped);
            mismatches++;
         end else begin
            want = pending_rgbw.pop_front();
            check_field("out_red", want.red, rsp_ch.out_red);
            check_field("out_green", want.green, rsp_ch.out_green);
            check_field("out_blue", want.blue, rsp_ch.out_blue);
            check_field("out_white", want.white, rsp_ch.out_white);
            check_field("white_clamped", want.clamped, rsp_ch.white_clamped);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rgb_to_rgbw_white_extraction: mismatch");
         $finish;
      end
   end

   initial begin
      pixel_type         px;
      white_setting_type setting;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.in_red = '0;
      req_ch.in_green = '0;
      req_ch.in_blue = '0;
      req_ch.gain = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      white_cfg.comp[CH_RED] = WHITE_COMP_RESET;
      white_cfg.comp[CH_GREEN] = WHITE_COMP_RESET;
      white_cfg.comp[CH_BLUE] = WHITE_COMP_RESET;
      white_cfg.max_white = MAX_WHITE_RESET;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         px = directed_rows[i].px;
         send_pixel(px, directed_rows[i].typed ? directed_rows[i].res : extract_white(px));
      end
      wait_drained();

      for (int p = 0; p < $size(fixed_settings) + RANDOM_PHASES; p++) begin
         setting = (p < $size(fixed_settings)) ? fixed_settings[p] : random_setting();
         // writes past the register list must leave the settings alone
         if (p == 1) begin
            write_reg(CSR_INDEX_PAST_END, '1);
            write_reg(CSR_INDEX_TOP, '0);
         end
         write_reg(CSR_WHITE_RED, setting.red);
         write_reg(CSR_WHITE_GREEN, setting.green);
         write_reg(CSR_WHITE_BLUE, setting.blue);
         write_reg(CSR_MAX_WHITE, setting.max_white);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            px = random_pixel();
            send_pixel(px, extract_white(px));
         end
         quiet = 1'b0;
         wait_drained();
      end

      repeat (LATENCY + 10) @(negedge clock);
      if (mismatches == 0 && pending_rgbw.size() == 0) begin
         $display("rgb_to_rgbw_white_extraction: match");
      end else begin
         $display("rgb_to_rgbw_white_extraction: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/rgbw_pkg.sv
sv/rgbw_if.sv
sv/rgbw_cfg.sv
sv/rgbw_amp.sv
sv/rgbw_div.sv
sv/rgbw_white.sv
sv/rgbw_out.sv
sv/rgb_to_rgbw_white_extraction.sv
test/tb_rgb_to_rgbw_white_extraction.sv
